// ===== rtl/lcfs_pkg.sv =====
// Package for the LED chain frame sender: sizes, command codes, payload types
// and the default LED table builder. Used by every module of the block.
`timescale 1ns / 1ps
package lcfs_pkg;

   localparam int SWITCH_LEDS   = 4;
   localparam int SWITCH_REPEAT = 2;
   localparam int ALL_LEDS      = SWITCH_LEDS + 1;
   localparam int LED_W         = (ALL_LEDS > 1) ? $clog2(ALL_LEDS) : 1;
   localparam int REP_W         = $clog2(SWITCH_REPEAT + 1);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W   = 3;
   localparam int FRAME_BYTES   = 8 + 4 * (SWITCH_LEDS * SWITCH_REPEAT + 1);

   localparam logic [1:0] CMD_SET     = 2'd0;
   localparam logic [1:0] CMD_APPLY   = 2'd1;
   localparam logic [1:0] CMD_RESTORE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHT_ON  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHT_OFF = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_ON   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_OFF  = 3'd5;

   localparam logic [7:0] RST_START_BYTE = 8'h00;
   localparam logic [7:0] RST_END_BYTE   = 8'hFF;
   localparam logic [7:0] RST_BRIGHT_ON  = 8'hFF;
   localparam logic [7:0] RST_BRIGHT_OFF = 8'hE0;
   localparam logic [7:0] RST_COLOR_ON   = 8'hFF;
   localparam logic [7:0] RST_COLOR_OFF  = 8'h00;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] led_index;
      logic       target_on;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] end_byte;
      logic [7:0] bright_on;
      logic [7:0] bright_off;
      logic [7:0] color_on;
      logic [7:0] color_off;
   } cfg_type;

   typedef logic [ALL_LEDS-1:0][31:0] led_words_type;

   typedef struct packed {
      logic          valid;
      led_words_type words;
   } queue_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic led_words_type default_words(logic [7:0] br, logic [7:0] con,
                                                   logic [7:0] coff);
      led_words_type w;
      for (int i = 0; i < SWITCH_LEDS; i++) begin
         w[i] = {br, con, coff, coff};
      end
      w[SWITCH_LEDS] = {br, coff, coff, con};
      return w;
   endfunction

endpackage

// ===== rtl/led_chain_frame_sender_unit.sv =====
// Top level of the LED chain frame sender: register file, front end, snapshot
// queue and frame back end. Depends on lcfs_pkg, lcfs_front, lcfs_queue, lcfs_back.
// With the back end idle, an accepted command's snapshot is written to the queue,
// and the first byte of its frame is then registered in the result output register.
// Throughput: one byte per cycle while rsp_stall is low, 44 bytes per frame (the
// back-end sequencer); the queue holds up to two pending frames.
// Reset: synchronous; restores registers, flags and LED words, sends no frame.
`timescale 1ns / 1ps
module led_chain_frame_sender_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lcfs_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lcfs_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lcfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_data
);
   import lcfs_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   queue_push_type   q_push;
   queue_status_type q_status;
   led_words_type    head;
   logic             pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_BYTE: cfg_in.start_byte = csr_data;
            CSR_END_BYTE:   cfg_in.end_byte   = csr_data;
            CSR_BRIGHT_ON:  cfg_in.bright_on  = csr_data;
            CSR_BRIGHT_OFF: cfg_in.bright_off = csr_data;
            CSR_COLOR_ON:   cfg_in.color_on   = csr_data;
            CSR_COLOR_OFF:  cfg_in.color_off  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte <= RST_START_BYTE;
         cfg_ff.end_byte   <= RST_END_BYTE;
         cfg_ff.bright_on  <= RST_BRIGHT_ON;
         cfg_ff.bright_off <= RST_BRIGHT_OFF;
         cfg_ff.color_on   <= RST_COLOR_ON;
         cfg_ff.color_off  <= RST_COLOR_OFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_push    (q_push)
   );

   lcfs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_status (q_status),
      .pop      (pop),
      .head     (head)
   );

   lcfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/lcfs_front.sv =====
// Front end: accepts commands, keeps the target/current flags and LED words,
// and queues an LED table snapshot for every frame. Depends on lcfs_pkg.
`timescale 1ns / 1ps
module lcfs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lcfs_pkg::req_type         req_data,
   input  lcfs_pkg::cfg_type         cfg,
   input  lcfs_pkg::queue_status_type q_status,
   output lcfs_pkg::queue_push_type  q_push
);
   import lcfs_pkg::*;

   logic [ALL_LEDS-1:0] target_ff, target_in;
   logic [ALL_LEDS-1:0] current_ff, current_in;
   led_words_type       words_ff, words_in;
   logic                accept;
   logic                in_range;
   logic [LED_W-1:0]    tidx;
   logic                push;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign in_range  = int'(req_data.led_index) <= SWITCH_LEDS;
   assign tidx      = LED_W'(req_data.led_index);

   always_comb begin
      target_in  = target_ff;
      current_in = current_ff;
      words_in   = words_ff;
      push       = 1'b0;
      if (accept) begin
         case (req_data.command)
            CMD_SET: begin
               if (in_range) begin
                  target_in[tidx] = req_data.target_on;
               end
            end
            CMD_APPLY: begin
               if (in_range && (current_ff[tidx] != target_ff[tidx])) begin
                  current_in[tidx]      = target_ff[tidx];
                  words_in[tidx][31:24] = target_ff[tidx] ? cfg.bright_on : cfg.bright_off;
                  push                  = 1'b1;
               end
            end
            CMD_RESTORE: begin
               target_in  = '1;
               current_in = '1;
               words_in   = default_words(cfg.bright_on, cfg.color_on, cfg.color_off);
               push       = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign q_push.valid = push;
   assign q_push.words = words_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '1;
         current_ff <= '1;
         words_ff   <= default_words(RST_BRIGHT_ON, RST_COLOR_ON, RST_COLOR_OFF);
      end else begin
         target_ff  <= target_in;
         current_ff <= current_in;
         words_ff   <= words_in;
      end
   end

   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push |-> accept)
      else $error("frame queued without an accepted command");

endmodule

// ===== rtl/lcfs_queue.sv =====
// Short queue of LED table snapshots between front and back end.
// Depends on lcfs_pkg.
`timescale 1ns / 1ps
module lcfs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  lcfs_pkg::queue_push_type   q_push,
   output lcfs_pkg::queue_status_type q_status,
   input  logic                       pop,
   output lcfs_pkg::led_words_type    head
);
   import lcfs_pkg::*;

   led_words_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign q_status.full  = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_status.empty = cnt_ff == '0;
   assign head           = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (q_push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push.valid && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !q_push.valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         entries_ff[wr_ptr_ff] <= q_push.words;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push.valid |-> !q_status.full)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

// ===== rtl/lcfs_back.sv =====
// Back end: walks the frame sequence for the queue head, one byte per cycle while
// the output is not stalled, into the result output register. Depends on lcfs_pkg.
`timescale 1ns / 1ps
module lcfs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  lcfs_pkg::cfg_type          cfg,
   input  lcfs_pkg::queue_status_type q_status,
   input  lcfs_pkg::led_words_type    head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lcfs_pkg::rsp_type          rsp_data
);
   import lcfs_pkg::*;

   localparam logic [1:0] SEC_START = 2'd0;
   localparam logic [1:0] SEC_LED   = 2'd1;
   localparam logic [1:0] SEC_END   = 2'd2;

   logic [1:0]       sec_ff, sec_in;
   logic [1:0]       sub_ff, sub_in;
   logic [REP_W-1:0] rep_ff, rep_in;
   logic [LED_W-1:0] led_ff, led_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             fire;
   logic [31:0]      word;
   rsp_type          gen;

   assign fire = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign word = head[led_ff];

   always_comb begin
      gen.last = 1'b0;
      case (sec_ff)
         SEC_START: gen.out_byte = cfg.start_byte;
         SEC_LED: begin
            case (sub_ff)
               2'd0:    gen.out_byte = word[31:24];
               2'd1:    gen.out_byte = word[23:16];
               2'd2:    gen.out_byte = word[15:8];
               default: gen.out_byte = word[7:0];
            endcase
         end
         SEC_END: begin
            gen.out_byte = cfg.end_byte;
            gen.last     = sub_ff == 2'd3;
         end
         default: gen.out_byte = cfg.end_byte;
      endcase
   end

   always_comb begin
      sec_in = sec_ff;
      sub_in = sub_ff;
      rep_in = rep_ff;
      led_in = led_ff;
      pop    = 1'b0;
      if (fire) begin
         sub_in = sub_ff + 1'b1;
         case (sec_ff)
            SEC_START: begin
               if (sub_ff == 2'd3) begin
                  sec_in = SEC_LED;
               end
            end
            SEC_LED: begin
               if (sub_ff == 2'd3) begin
                  if (led_ff == LED_W'(SWITCH_LEDS)) begin
                     sec_in = SEC_END;
                     led_in = '0;
                     rep_in = '0;
                  end else if (rep_ff == REP_W'(SWITCH_REPEAT - 1)) begin
                     rep_in = '0;
                     led_in = led_ff + 1'b1;
                  end else begin
                     rep_in = rep_ff + 1'b1;
                  end
               end
            end
            SEC_END: begin
               if (sub_ff == 2'd3) begin
                  sec_in = SEC_START;
                  pop    = 1'b1;
               end
            end
            default: begin
               sec_in = SEC_START;
               sub_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = gen;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff       <= SEC_START;
         sub_ff       <= '0;
         rep_ff       <= '0;
         led_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sec_ff       <= sec_in;
         sub_ff       <= sub_in;
         rep_ff       <= rep_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_idle_at_frame_start: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> (sec_ff == SEC_START) && (sub_ff == 2'd0))
      else $error("sequencer mid-frame with no frame queued");

   a_last_pops: assert property (@(posedge clock) disable iff (reset)
      (fire && gen.last) |-> pop)
      else $error("final frame byte without releasing the queue head");

endmodule
